FILE: src/utf8d_pkg.sv
// Shared types and constants for the UTF-8 to UCS-4 stream decoder.
package utf8d_pkg;

  localparam int unsigned COUNT_BITS = 24;
  localparam int unsigned CP_BITS    = 31;
  localparam int unsigned LEN_BITS   = 3;
  localparam int unsigned BYTE_BITS  = 8;
  localparam int unsigned IN_TDATA_BITS  = 8;
  localparam int unsigned OUT_TDATA_BITS = 64;
  localparam int unsigned OUT_TUSER_BITS = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_ILLEGAL    = 2'd1,
    STATUS_SRC_EXHAUST = 2'd2,
    STATUS_TGT_EXHAUST = 2'd3
  } status_e;

  typedef struct packed {
    logic [LEN_BITS-1:0]   bytes_left;
    logic [LEN_BITS-1:0]   seq_len;
    logic [CP_BITS-1:0]    acc;
    logic [COUNT_BITS-1:0] chars_done;
    logic                  dropping;
  } dec_state_t;

  typedef struct packed {
    logic [CP_BITS-1:0]    code_point;
    logic [LEN_BITS-1:0]   seq_length;
    status_e               status;
    logic [COUNT_BITS-1:0] char_count;
    logic                  buffer_done;
  } dec_result_t;

endpackage

FILE: src/utf8_to_ucs4_stream_decoder.sv
// Top level of the UTF-8 (1 to 6 byte form) to UCS-4 stream decoder.
//
//  Channel   Direction  Word contents
//  s_axis    in         tdata[7:0] data_byte, tlast end_of_buffer
//  m_axis    out        tdata code_point/seq_length/char_count, tuser status,
//                       tlast buffer_done
//  cfg       in         cfg_we_i/cfg_wdata_i write output_capacity
//
// One word is accepted per cycle while the output does not stall. A word passes an
// input register, then one decode step writes the result register when the byte
// ends a character or an error. Reset clears the decoder state and the capacity.
// A stalled output holds the result register and the input register while
// the input stays ready until both are full.
module utf8_to_ucs4_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] data_byte.
  input  logic [utf8d_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [30:0] code_point, [33:31] seq_length, [57:34] char_count, rest zero.
  output logic [utf8d_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
  // [1:0] status.
  output logic [utf8d_pkg::OUT_TUSER_BITS-1:0] m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [utf8d_pkg::COUNT_BITS-1:0]     cfg_wdata_i
);

  logic                                  in_valid_q;
  logic [utf8d_pkg::BYTE_BITS-1:0]       in_byte_q;
  logic                                  in_eob_q;
  logic                                  out_valid_q;
  logic                                  out_valid_d;
  utf8d_pkg::dec_result_t                out_q;
  utf8d_pkg::dec_state_t                 state_q;
  utf8d_pkg::dec_state_t                 state_d;
  utf8d_pkg::dec_result_t                res;
  logic                                  emit;
  logic [utf8d_pkg::COUNT_BITS-1:0]      capacity_q;
  logic                                  advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  utf8d_step u_step (
    .state_i    (state_q),
    .byte_i     (in_byte_q),
    .eob_i      (in_eob_q),
    .capacity_i (capacity_q),
    .state_o    (state_d),
    .emit_o     (emit),
    .result_o   (res)
  );

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    if (advance && emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
      capacity_q  <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        state_q <= state_d;
      end
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata[utf8d_pkg::BYTE_BITS-1:0];
      in_eob_q  <= s_axis_tlast;
    end
    if (advance && emit) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.char_count, out_q.seq_length, out_q.code_point};
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.buffer_done;

endmodule

FILE: src/utf8d_step.sv
// Combinational decode step: one byte against the decoder state.
module utf8d_step (
  input  utf8d_pkg::dec_state_t                  state_i,
  input  logic [utf8d_pkg::BYTE_BITS-1:0]        byte_i,
  input  logic                                   eob_i,
  input  logic [utf8d_pkg::COUNT_BITS-1:0]       capacity_i,
  output utf8d_pkg::dec_state_t                  state_o,
  output logic                                   emit_o,
  output utf8d_pkg::dec_result_t                 result_o
);

  logic                                  do_complete;
  logic                                  do_fail;
  utf8d_pkg::status_e                    fail_code;
  logic [utf8d_pkg::CP_BITS-1:0]         cp;
  logic [utf8d_pkg::LEN_BITS-1:0]        len;
  logic [utf8d_pkg::LEN_BITS-1:0]        lead_len;
  logic [utf8d_pkg::CP_BITS-1:0]         lead_bits;
  logic [utf8d_pkg::CP_BITS-1:0]         acc_next;
  logic [utf8d_pkg::LEN_BITS-1:0]        left_next;
  logic [utf8d_pkg::COUNT_BITS-1:0]      count_inc;
  logic                                  cap_hit;
  utf8d_pkg::dec_state_t                 mid_state;

  always_comb begin
    lead_len  = '0;
    lead_bits = '0;
    if (byte_i[7:5] == 3'b110) begin
      lead_len  = 3'd2;
      lead_bits = {26'd0, byte_i[4:0]};
    end else if (byte_i[7:4] == 4'b1110) begin
      lead_len  = 3'd3;
      lead_bits = {27'd0, byte_i[3:0]};
    end else if (byte_i[7:3] == 5'b11110) begin
      lead_len  = 3'd4;
      lead_bits = {28'd0, byte_i[2:0]};
    end else if (byte_i[7:2] == 6'b111110) begin
      lead_len  = 3'd5;
      lead_bits = {29'd0, byte_i[1:0]};
    end else if (byte_i[7:1] == 7'b1111110) begin
      lead_len  = 3'd6;
      lead_bits = {30'd0, byte_i[0]};
    end
  end

  assign acc_next  = {state_i.acc[utf8d_pkg::CP_BITS-7:0], byte_i[5:0]};
  assign left_next = state_i.bytes_left - 3'd1;
  assign cap_hit   = (capacity_i != '0) && (state_i.chars_done >= capacity_i);
  assign count_inc = (state_i.chars_done != utf8d_pkg::COUNT_MAX) ?
                     state_i.chars_done + 1'b1 : state_i.chars_done;

  always_comb begin
    do_complete = 1'b0;
    do_fail     = 1'b0;
    fail_code   = utf8d_pkg::STATUS_OK;
    cp          = '0;
    len         = '0;
    mid_state   = state_i;
    if (state_i.dropping) begin
      if (eob_i) begin
        mid_state = '0;
      end
    end else if (state_i.bytes_left == '0) begin
      if (!byte_i[7]) begin
        do_complete = 1'b1;
        cp          = {23'd0, byte_i};
        len         = 3'd1;
      end else if (lead_len == '0) begin
        do_fail   = 1'b1;
        fail_code = utf8d_pkg::STATUS_ILLEGAL;
      end else if (eob_i) begin
        do_fail   = 1'b1;
        fail_code = utf8d_pkg::STATUS_SRC_EXHAUST;
      end else begin
        mid_state.acc        = lead_bits;
        mid_state.seq_len    = lead_len;
        mid_state.bytes_left = lead_len - 3'd1;
      end
    end else begin
      if (left_next == '0) begin
        do_complete = 1'b1;
        cp          = acc_next;
        len         = state_i.seq_len;
      end else if (eob_i) begin
        do_fail   = 1'b1;
        fail_code = utf8d_pkg::STATUS_SRC_EXHAUST;
      end else begin
        mid_state.acc        = acc_next;
        mid_state.bytes_left = left_next;
      end
    end
    if (do_complete && cap_hit) begin
      do_complete = 1'b0;
      do_fail     = 1'b1;
      fail_code   = utf8d_pkg::STATUS_TGT_EXHAUST;
    end
  end

  always_comb begin
    state_o  = mid_state;
    emit_o   = do_complete || do_fail;
    result_o = '0;
    if (do_fail) begin
      result_o.status      = fail_code;
      result_o.char_count  = state_i.chars_done;
      result_o.buffer_done = 1'b1;
      state_o              = '0;
      state_o.dropping     = !eob_i;
    end else if (do_complete) begin
      result_o.code_point  = cp;
      result_o.seq_length  = len;
      result_o.status      = utf8d_pkg::STATUS_OK;
      result_o.char_count  = count_inc;
      result_o.buffer_done = eob_i;
      state_o              = '0;
      if (!eob_i) begin
        state_o.chars_done = count_inc;
      end
    end
  end

endmodule

FILE: dv/tb_utf8_to_ucs4_stream_decoder.sv
// Self-checking testbench for the UTF-8 to UCS-4 stream decoder with random stalls.
`timescale 1ns / 1ps

module tb_utf8_to_ucs4_stream_decoder;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_WORDS = 136;
  localparam logic [8:0] DIRECTED [31] = '{
    9'h000, 9'h07F, 9'h0DF, 9'h0BF, 9'h0EF, 9'h0BF, 9'h0BF,
    9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0FB, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF,
    9'h0FD, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h1BF,
    9'h080, 9'h041, 9'h142, 9'h1FE, 9'h0FF, 9'h141, 9'h0E2, 9'h182, 9'h1C3
  };

  typedef struct {
    logic [7:0]  data;
    logic        last;
    int unsigned gap;
    logic        drain;
  } tx_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [utf8d_pkg::IN_TDATA_BITS-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [utf8d_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata;
  logic [utf8d_pkg::OUT_TUSER_BITS-1:0] m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_we_i = 1'b0;
  logic [utf8d_pkg::COUNT_BITS-1:0] cfg_wdata_i = '0;

  tx_word_t tx_bytes[$];
  utf8d_pkg::dec_result_t pending_chars[$];
  utf8d_pkg::dec_state_t dec_st = '0;
  logic [utf8d_pkg::COUNT_BITS-1:0] cap_limit = '0;
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  logic tx_quiet = 1'b0;
  logic rx_quiet = 1'b0;
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  int unsigned rx_draw = 0;
  int unsigned sent = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  utf8d_pkg::dec_result_t got_char;
  utf8d_pkg::dec_result_t exp_char;

  utf8_to_ucs4_stream_decoder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic utf8d_pkg::dec_result_t char_error(input utf8d_pkg::status_e st,
                                                        input logic eob);
    utf8d_pkg::dec_result_t r;
    r = '0;
    r.status = st;
    r.char_count = dec_st.chars_done;
    r.buffer_done = 1'b1;
    dec_st = '0;
    dec_st.dropping = !eob;
    return r;
  endfunction

  function automatic utf8d_pkg::dec_result_t char_done(
      input logic [utf8d_pkg::CP_BITS-1:0] cp,
      input logic [utf8d_pkg::LEN_BITS-1:0] len,
      input logic eob);
    utf8d_pkg::dec_result_t r;
    if (cap_limit != 0 && dec_st.chars_done >= cap_limit) begin
      return char_error(utf8d_pkg::STATUS_TGT_EXHAUST, eob);
    end
    if (dec_st.chars_done != utf8d_pkg::COUNT_MAX) begin
      dec_st.chars_done = dec_st.chars_done + 1'b1;
    end
    r.code_point = cp;
    r.seq_length = len;
    r.status = utf8d_pkg::STATUS_OK;
    r.char_count = dec_st.chars_done;
    r.buffer_done = eob;
    dec_st.bytes_left = '0;
    dec_st.seq_len = '0;
    dec_st.acc = '0;
    if (eob) begin
      dec_st = '0;
    end
    return r;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic eob);
    logic [utf8d_pkg::LEN_BITS-1:0] n;
    logic [utf8d_pkg::CP_BITS-1:0] lead;
    if (dec_st.dropping) begin
      if (eob) begin
        dec_st = '0;
      end
    end else if (dec_st.bytes_left == 0) begin
      n = '0;
      lead = '0;
      casez (b)
        8'b0???????: begin n = 3'd1; lead = utf8d_pkg::CP_BITS'(b); end
        8'b110?????: begin n = 3'd2; lead = utf8d_pkg::CP_BITS'(b[4:0]); end
        8'b1110????: begin n = 3'd3; lead = utf8d_pkg::CP_BITS'(b[3:0]); end
        8'b11110???: begin n = 3'd4; lead = utf8d_pkg::CP_BITS'(b[2:0]); end
        8'b111110??: begin n = 3'd5; lead = utf8d_pkg::CP_BITS'(b[1:0]); end
        8'b1111110?: begin n = 3'd6; lead = utf8d_pkg::CP_BITS'(b[0]); end
        default: n = '0;
      endcase
      if (n == 3'd1) begin
        pending_chars.push_back(char_done(lead, n, eob));
      end else if (n == 0) begin
        pending_chars.push_back(char_error(utf8d_pkg::STATUS_ILLEGAL, eob));
      end else if (eob) begin
        pending_chars.push_back(char_error(utf8d_pkg::STATUS_SRC_EXHAUST, eob));
      end else begin
        dec_st.acc = lead;
        dec_st.seq_len = n;
        dec_st.bytes_left = n - 1'b1;
      end
    end else begin
      dec_st.acc = {dec_st.acc[utf8d_pkg::CP_BITS-7:0], b[5:0]};
      dec_st.bytes_left = dec_st.bytes_left - 1'b1;
      if (dec_st.bytes_left == 0) begin
        pending_chars.push_back(char_done(dec_st.acc, dec_st.seq_len, eob));
      end else if (eob) begin
        pending_chars.push_back(char_error(utf8d_pkg::STATUS_SRC_EXHAUST, eob));
      end
    end
  endfunction

  always @(posedge clk_i) begin
    in_fire <= s_axis_tvalid && s_axis_tready;
    out_fire <= m_axis_tvalid && m_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_char.code_point = m_axis_tdata[30:0];
        got_char.seq_length = m_axis_tdata[33:31];
        got_char.status = utf8d_pkg::status_e'(m_axis_tuser);
        got_char.char_count = m_axis_tdata[57:34];
        got_char.buffer_done = m_axis_tlast;
        if (pending_chars.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected word: cp=%h len=%0d st=%0d cnt=%0d done=%b",
                     got_char.code_point, got_char.seq_length, got_char.status,
                     got_char.char_count, got_char.buffer_done);
          end
          mismatches++;
        end else begin
          exp_char = pending_chars.pop_front();
          if (got_char !== exp_char || m_axis_tdata[63:58] !== '0) begin
            if (mismatches < 10) begin
              $display("mismatch: expected cp=%h len=%0d st=%0d cnt=%0d done=%b",
                       exp_char.code_point, exp_char.seq_length, exp_char.status,
                       exp_char.char_count, exp_char.buffer_done);
              $display("          got      cp=%h len=%0d st=%0d cnt=%0d done=%b pad=%h",
                       got_char.code_point, got_char.seq_length, got_char.status,
                       got_char.char_count, got_char.buffer_done, m_axis_tdata[63:58]);
            end
            mismatches++;
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && !in_fire) begin
        s_axis_tvalid <= 1'b1;
      end else if (tx_bytes.size() != 0 && tx_wait < tx_bytes[0].gap) begin
        tx_wait <= tx_wait + 1;
        s_axis_tvalid <= 1'b0;
      end else if (tx_bytes.size() != 0 &&
                   !(tx_bytes[0].drain && pending_chars.size() != 0)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= tx_bytes[0].data;
        s_axis_tlast <= tx_bytes[0].last;
        tx_wait <= 0;
        void'(tx_bytes.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!m_axis_tready) begin
        if (rx_wait == 0) begin
          m_axis_tready <= 1'b1;
        end else begin
          rx_wait <= rx_wait - 1;
        end
      end else if (out_fire) begin
        if ($urandom_range(0, 49) == 0) begin
          rx_quiet <= !rx_quiet;
        end
        rx_draw = rx_quiet ? 0 : $urandom_range(0, 13);
        if (rx_draw != 0) begin
          m_axis_tready <= 1'b0;
          rx_wait <= rx_draw - 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic last, input logic drain);
    tx_word_t w;
    w.data = d;
    w.last = last;
    w.gap = tx_quiet ? 0 : $urandom_range(0, 13);
    w.drain = drain;
    tx_bytes.push_back(w);
    sent++;
  endtask

  function automatic logic [7:0] lead_byte(input int unsigned n);
    logic [7:0] r;
    r = 8'($urandom);
    case (n)
      1: return {1'b0, r[6:0]};
      2: return {3'b110, r[4:0]};
      3: return {4'b1110, r[3:0]};
      4: return {5'b11110, r[2:0]};
      5: return {6'b111110, r[1:0]};
      default: return {7'b1111110, r[0]};
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    logic [7:0] r;
    r = 8'($urandom);
    return ($urandom_range(0, 7) == 0) ? r : {2'b10, r[5:0]};
  endfunction

  task automatic gen_buffer(input logic drain_first);
    logic [7:0] bq[$];
    logic [7:0] r;
    int unsigned mode;
    int unsigned nchars;
    int unsigned len;
    int unsigned cut;
    int unsigned bad_at;
    mode = $urandom_range(0, 9);
    nchars = $urandom_range(1, 7);
    bad_at = $urandom_range(0, nchars - 1);
    for (int i = 0; i < nchars; i++) begin
      if (mode == 7 && i == bad_at) begin
        r = 8'($urandom);
        bq.push_back(r[0] ? {2'b10, r[7:2]} : {7'b1111111, r[1]});
      end
      len = $urandom_range(1, 6);
      bq.push_back(lead_byte(len));
      for (int k = 1; k < len; k++) begin
        bq.push_back(cont_byte());
      end
    end
    if (mode == 8) begin
      len = $urandom_range(2, 6);
      cut = $urandom_range(1, len - 1);
      bq.push_back(lead_byte(len));
      for (int k = 1; k < cut; k++) begin
        bq.push_back(cont_byte());
      end
    end
    if (mode == 9) begin
      bq.delete();
      repeat ($urandom_range(1, 8)) bq.push_back(8'($urandom));
    end
    if ($urandom_range(0, 9) == 0) begin
      tx_quiet = !tx_quiet;
    end
    foreach (bq[i]) begin
      send_byte(bq[i], i == bq.size() - 1, drain_first && i == 0);
    end
  endtask

  task automatic wait_idle();
    while (tx_bytes.size() != 0 || s_axis_tvalid || pending_chars.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic set_capacity(input logic [utf8d_pkg::COUNT_BITS-1:0] v);
    wait_idle();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    cap_limit = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned target;
    int unsigned nbuf;
    logic [utf8d_pkg::COUNT_BITS-1:0] cap;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_capacity('0);
    foreach (DIRECTED[i]) begin
      send_byte(DIRECTED[i][7:0], DIRECTED[i][8], 1'b0);
    end
    set_capacity(24'd1);
    send_byte(8'h41, 1'b0, 1'b0);
    send_byte(8'h42, 1'b0, 1'b0);
    send_byte(8'h43, 1'b1, 1'b0);

    target = sent;
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: cap = utf8d_pkg::COUNT_MAX;
        1: cap = utf8d_pkg::COUNT_BITS'($urandom_range(2, 5));
        2: cap = '0;
        3: cap = utf8d_pkg::COUNT_BITS'($urandom_range(1, 8));
        4: cap = utf8d_pkg::COUNT_BITS'($urandom);
        5: cap = 24'd3;
        default: cap = utf8d_pkg::COUNT_BITS'($urandom_range(1, 4));
      endcase
      set_capacity(cap);
      target += PHASE_WORDS;
      nbuf = 0;
      while (sent < target) begin
        gen_buffer(nbuf == 3 || $urandom_range(0, 29) == 0);
        nbuf++;
      end
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
